### design/psu_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; every other design file refers to this package by scoped names.
package psu_pkg;

   localparam int MaxLineBytes  = 8192;
   localparam int MaxPixelBytes = 8;
   localparam int LineAddrW     = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1;
   localparam int PixTapW       = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;
   localparam int ColW          = 14;
   localparam int PixSizeW      = 4;
   localparam int CsrDataW      = 14;
   localparam int CsrIndexW     = 1;
   localparam int ByteW         = 8;

   typedef enum logic [2:0] {
      FILT_NONE    = 3'd0,
      FILT_SUB     = 3'd1,
      FILT_UP      = 3'd2,
      FILT_AVG     = 3'd3,
      FILT_PAETH   = 3'd4,
      FILT_UNKNOWN = 3'd5
   } filter_kind_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_LINE_LENGTH = 1'b0,
      REG_PIXEL_BYTES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             start_of_image;
   } req_word_type;

   typedef struct packed {
      logic [ByteW-1:0] pixel_byte;
      logic             end_of_line;
      logic             unknown_filter;
   } rsp_word_type;

   // One accepted byte on its way through the compute stage
   typedef struct packed {
      logic             is_filter;
      filter_kind_type  kind;
      logic [ColW-1:0]  x;
      logic             first_row;
      logic             eol;
      logic [ByteW-1:0] data_byte;
   } stage_type;

   typedef struct packed {
      logic                 en;
      logic [LineAddrW-1:0] addr;
      logic [ByteW-1:0]     data;
   } lb_write_type;

   function automatic logic [ByteW-1:0] paeth(input logic [ByteW-1:0] a,
                                              input logic [ByteW-1:0] b,
                                              input logic [ByteW-1:0] c);
      logic [ByteW-1:0] pa;
      logic [ByteW-1:0] pb;
      logic [ByteW:0]   pc;
      logic [ByteW:0]   sum_ab;
      logic [ByteW:0]   two_c;
      logic [ByteW-1:0] pick;
      // p = a + b - c, so |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
      pa     = (b >= c) ? (b - c) : (c - b);
      pb     = (a >= c) ? (a - c) : (c - a);
      sum_ab = {1'b0, a} + {1'b0, b};
      two_c  = {c, 1'b0};
      pc     = (sum_ab >= two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
      if ((pa <= pb) && ({1'b0, pa} <= pc)) begin
         pick = a;
      end else if ({1'b0, pb} <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

### design/psu_line_buf.sv
// Prior-row line buffer: one write port and one registered read port.
// Depends on psu_pkg for depth, address width and the write struct.
module psu_line_buf (
   input  logic                         clock,
   input  psu_pkg::lb_write_type        wr,
   input  logic                         rd_en,
   input  logic [psu_pkg::LineAddrW-1:0] rd_addr,
   output logic [psu_pkg::ByteW-1:0]    rd_data
);

   logic [psu_pkg::ByteW-1:0] mem [psu_pkg::MaxLineBytes];
   logic [psu_pkg::ByteW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read data stays put until the next read, so a stalled stage keeps it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/psu_ctrl.sv
// Input side: column and row tracking at acceptance, line buffer read issue and
// the compute-stage register. Depends on psu_pkg.
module psu_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  psu_pkg::req_word_type         req_word,
   input  logic [psu_pkg::ColW-1:0]      line_length,
   input  logic                          out_free,
   output logic                          s1_valid,
   output logic                          s1_adv,
   output psu_pkg::stage_type            s1_word,
   output logic                          rd_en,
   output logic [psu_pkg::LineAddrW-1:0] rd_addr
);

   logic [psu_pkg::ColW-1:0]  col_ff, col_in;
   logic                      first_row_ff, first_row_in;
   psu_pkg::filter_kind_type  kind_ff, kind_in;
   logic                      s1_valid_ff, s1_valid_in;
   psu_pkg::stage_type        s1_ff, s1_in;

   logic                      req_fire;
   logic [psu_pkg::ColW-1:0]  col_cur;
   logic                      first_cur;
   logic [psu_pkg::ColW-1:0]  len_eff;
   logic [psu_pkg::ColW:0]    col_next;
   logic                      eol;

   assign s1_adv    = s1_valid_ff && (s1_ff.is_filter || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      col_cur   = req_word.start_of_image ? '0 : col_ff;
      first_cur = req_word.start_of_image ? 1'b1 : first_row_ff;
      len_eff   = (line_length < psu_pkg::ColW'(2)) ? psu_pkg::ColW'(2) : line_length;
      col_next  = {1'b0, col_cur} + (psu_pkg::ColW + 1)'(1);
      eol       = col_next >= {1'b0, len_eff};

      col_in       = col_ff;
      first_row_in = first_row_ff;
      kind_in      = kind_ff;

      s1_in.data_byte = req_word.data_byte;
      s1_in.first_row = first_cur;
      s1_in.kind      = kind_ff;
      s1_in.x         = col_cur - psu_pkg::ColW'(1);
      s1_in.is_filter = 1'b0;
      s1_in.eol       = 1'b0;

      if (req_fire) begin
         if (col_cur == '0) begin
            // filter type byte: latch the kind, no result
            kind_in         = (req_word.data_byte > psu_pkg::ByteW'(4)) ?
                              psu_pkg::FILT_UNKNOWN :
                              psu_pkg::filter_kind_type'(req_word.data_byte[2:0]);
            col_in          = psu_pkg::ColW'(1);
            first_row_in    = first_cur;
            s1_in.is_filter = 1'b1;
         end else begin
            s1_in.eol    = eol;
            col_in       = eol ? '0 : col_next[psu_pkg::ColW-1:0];
            first_row_in = eol ? 1'b0 : first_cur;
         end
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         kind_ff      <= psu_pkg::FILT_NONE;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         kind_ff      <= kind_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // fetch the upper neighbor alongside the byte
   assign rd_en    = req_fire;
   assign rd_addr  = psu_pkg::LineAddrW'(s1_in.x);
   assign s1_valid = s1_valid_ff;
   assign s1_word  = s1_ff;

endmodule

### design/psu_recon.sv
// Compute stage: neighbor histories, filter prediction, result register and the
// line buffer write-back. Depends on psu_pkg.
module psu_recon (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             s1_valid,
   input  logic                             s1_adv,
   input  psu_pkg::stage_type               s1_word,
   input  logic [psu_pkg::ByteW-1:0]        rd_data,
   input  logic [psu_pkg::PixSizeW-1:0]     pixel_bytes,
   output logic                             out_free,
   output psu_pkg::lb_write_type            lb_wr,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output psu_pkg::rsp_word_type            rsp_word
);

   logic [psu_pkg::ByteW-1:0] left_ff    [psu_pkg::MaxPixelBytes];
   logic [psu_pkg::ByteW-1:0] left_in    [psu_pkg::MaxPixelBytes];
   logic [psu_pkg::ByteW-1:0] upleft_ff  [psu_pkg::MaxPixelBytes];
   logic [psu_pkg::ByteW-1:0] upleft_in  [psu_pkg::MaxPixelBytes];
   logic                      rsp_valid_ff, rsp_valid_in;
   psu_pkg::rsp_word_type     rsp_ff;

   logic [psu_pkg::PixTapW-1:0] tap;
   logic                        in_buf;
   logic [psu_pkg::ByteW-1:0]   a, b, c, pred, result;
   logic [psu_pkg::ByteW:0]     sum_ab;
   logic                        emit;

   always_comb begin
      if (pixel_bytes == '0) begin
         tap = '0;
      end else if (32'(pixel_bytes) > psu_pkg::MaxPixelBytes) begin
         tap = psu_pkg::PixTapW'(psu_pkg::MaxPixelBytes - 1);
      end else begin
         tap = psu_pkg::PixTapW'(pixel_bytes - psu_pkg::PixSizeW'(1));
      end
   end

   assign in_buf = 32'(s1_word.x) < psu_pkg::MaxLineBytes;
   assign a      = left_ff[tap];
   assign c      = upleft_ff[tap];
   assign b      = (s1_word.first_row || !in_buf) ? '0 : rd_data;
   assign sum_ab = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s1_word.kind)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = sum_ab[psu_pkg::ByteW:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
         default:             pred = '0;
      endcase
   end

   assign result   = s1_word.data_byte + pred;
   assign emit     = s1_adv && !s1_word.is_filter;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
         left_in[i]   = left_ff[i];
         upleft_in[i] = upleft_ff[i];
      end
      if (s1_adv) begin
         if (s1_word.is_filter) begin
            // new scanline: no left neighbors yet
            for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
               left_in[i]   = '0;
               upleft_in[i] = '0;
            end
         end else begin
            for (int i = psu_pkg::MaxPixelBytes - 1; i > 0; i--) begin
               left_in[i]   = left_ff[i-1];
               upleft_in[i] = upleft_ff[i-1];
            end
            left_in[0]   = result;
            upleft_in[0] = b;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
            left_ff[i]   <= left_in[i];
            upleft_ff[i] <= upleft_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.pixel_byte     <= result;
         rsp_ff.end_of_line    <= s1_word.eol;
         rsp_ff.unknown_filter <= (s1_word.kind == psu_pkg::FILT_UNKNOWN);
      end
   end

   // store the rebuilt byte for the next row; columns past the buffer are dropped
   assign lb_wr.en   = emit && in_buf && s1_valid;
   assign lb_wr.addr = psu_pkg::LineAddrW'(s1_word.x);
   assign lb_wr.data = result;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### design/png_scanline_unfilter.sv
// PNG scanline unfilter: takes one inflated image byte per clock and rebuilds
// pixel bytes with filters none, sub, up, average and Paeth. A new byte is
// accepted in every cycle unless a pixel word waits in the result register
// while the compute stage holds another pixel byte. A pixel byte enters the
// compute stage register when it is accepted and moves on into the result register
// once that register is free or is being emptied, and its word then shows on rsp;
// filter type bytes give no word. The prior-row line buffer does one read (at
// acceptance) and one write (from the compute stage) per cycle; a column is
// always written at least one byte before the next row reads it, so the two
// never collide. The line buffer needs no clearing pass: the first row of an
// image reads zeros above.
// Configuration (line_length, pixel_bytes) may only change while no bytes are
// in flight.
module png_scanline_unfilter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  psu_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output psu_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_write,
   input  logic [psu_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [psu_pkg::CsrDataW-1:0]    csr_data
);

   logic [psu_pkg::ColW-1:0]     line_length_ff;
   logic [psu_pkg::PixSizeW-1:0] pixel_bytes_ff;

   logic                          out_free;
   logic                          s1_valid;
   logic                          s1_adv;
   psu_pkg::stage_type            s1_word;
   logic                          rd_en;
   logic [psu_pkg::LineAddrW-1:0] rd_addr;
   logic [psu_pkg::ByteW-1:0]     rd_data;
   psu_pkg::lb_write_type         lb_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= psu_pkg::ColW'(2);
         pixel_bytes_ff <= psu_pkg::PixSizeW'(1);
      end else if (csr_write) begin
         unique case (psu_pkg::csr_index_type'(csr_index))
            psu_pkg::REG_LINE_LENGTH: line_length_ff <= psu_pkg::ColW'(csr_data);
            psu_pkg::REG_PIXEL_BYTES: pixel_bytes_ff <= csr_data[psu_pkg::PixSizeW-1:0];
            default: ;
         endcase
      end
   end

   psu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .line_length (line_length_ff),
      .out_free    (out_free),
      .s1_valid    (s1_valid),
      .s1_adv      (s1_adv),
      .s1_word     (s1_word),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   psu_line_buf u_line_buf (
      .clock   (clock),
      .wr      (lb_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psu_recon u_recon (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_adv      (s1_adv),
      .s1_word     (s1_word),
      .rd_data     (rd_data),
      .pixel_bytes (pixel_bytes_ff),
      .out_free    (out_free),
      .lb_wr       (lb_wr),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

`ifndef NO_ASSERTIONS
   // a stalled compute stage keeps its byte
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid && !s1_adv |=> s1_valid && $stable(s1_word))
      else $error("compute stage changed while stalled");

   // an empty compute stage never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid |-> req_ready)
      else $error("input blocked with empty compute stage");

   // line buffer is written only by a pixel byte leaving the compute stage
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      lb_wr.en |-> s1_valid && s1_adv && !s1_word.is_filter)
      else $error("line buffer written without a finished pixel byte");

   // a finished pixel byte is always presented on the result port
   a_emit_visible: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_word.is_filter |=> rsp_valid)
      else $error("pixel byte left compute stage but no result shown");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for png_scanline_unfilter: sends filtered image bytes,
// rebuilds each one with its own unfilter model and compares every pixel word.
// Depends on psu_pkg and the png_scanline_unfilter RTL.
module tb_top;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 200;
   localparam int MAX_GAP       = 20;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   psu_pkg::req_word_type         req_word  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   psu_pkg::rsp_word_type         rsp_word;
   logic                          csr_write = 1'b0;
   logic [psu_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [psu_pkg::CsrDataW-1:0]  csr_data  = '0;

   // unfilter model state
   logic [psu_pkg::ByteW-1:0]     prior_line  [psu_pkg::MaxLineBytes];
   logic [psu_pkg::ByteW-1:0]     left_hist   [psu_pkg::MaxPixelBytes];
   logic [psu_pkg::ByteW-1:0]     upleft_hist [psu_pkg::MaxPixelBytes];
   int unsigned                   col_pos;
   bit                            in_first_row;
   psu_pkg::filter_kind_type      row_filter;
   logic [psu_pkg::ColW-1:0]      line_len_reg;
   logic [psu_pkg::PixSizeW-1:0]  pix_bytes_reg;
   int unsigned                   prior_extent;
   bit                            force_start;

   psu_pkg::rsp_word_type         expected_pixels [$];
   psu_pkg::rsp_word_type         want_pixel;

   int unsigned          cycle_count    = 0;
   int                   error_count    = 0;
   int                   bytes_sent     = 0;
   int                   pixels_checked = 0;
   int                   reg_writes     = 0;
   int                   send_idle_pct  = 0;
   int                   recv_idle_pct  = 0;
   int                   holds_requested = 0;
   int                   holds_served    = 0;
   int                   hold_left       = 0;

   png_scanline_unfilter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned clamp_len(input logic [psu_pkg::ColW-1:0] len);
      return (len < 2) ? 2 : len;
   endfunction

   function automatic int paeth_pick(input int a, input int b, input int c);
      int p, pa, pb, pc;
      p  = a + b - c;
      pa = (p > a) ? p - a : a - p;
      pb = (p > b) ? p - b : b - p;
      pc = (p > c) ? p - c : c - p;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   // pixel_bytes with random junk in the unused upper data bits
   function automatic logic [psu_pkg::CsrDataW-1:0] pix_word(input int unsigned px);
      logic [psu_pkg::CsrDataW-1:0] d;
      d = psu_pkg::CsrDataW'($urandom);
      d[psu_pkg::PixSizeW-1:0] = px[psu_pkg::PixSizeW-1:0];
      return d;
   endfunction

   task automatic rebuild_byte(input psu_pkg::req_word_type w);
      int unsigned               eff_len, bpp, x;
      int                        a, b, c, pred;
      logic [psu_pkg::ByteW-1:0] pixel;
      psu_pkg::rsp_word_type     want;
      eff_len = clamp_len(line_len_reg);
      bpp = (pix_bytes_reg == 0) ? 1 : pix_bytes_reg;
      if (bpp > psu_pkg::MaxPixelBytes) bpp = psu_pkg::MaxPixelBytes;
      if (w.start_of_image) begin
         col_pos      = 0;
         in_first_row = 1'b1;
      end
      if (col_pos == 0) begin
         row_filter = (w.data_byte > 4) ? psu_pkg::FILT_UNKNOWN :
                      psu_pkg::filter_kind_type'(w.data_byte[2:0]);
         for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
            left_hist[i]   = '0;
            upleft_hist[i] = '0;
         end
         col_pos = 1;
      end else begin
         x = col_pos - 1;
         a = left_hist[bpp-1];
         b = (!in_first_row && x < psu_pkg::MaxLineBytes) ? prior_line[x] : 0;
         c = upleft_hist[bpp-1];
         case (row_filter)
            psu_pkg::FILT_SUB:   pred = a;
            psu_pkg::FILT_UP:    pred = b;
            psu_pkg::FILT_AVG:   pred = (a + b) / 2;
            psu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
            default:             pred = 0;
         endcase
         pixel = psu_pkg::ByteW'(w.data_byte + pred);
         for (int i = psu_pkg::MaxPixelBytes - 1; i > 0; i--) begin
            left_hist[i]   = left_hist[i-1];
            upleft_hist[i] = upleft_hist[i-1];
         end
         left_hist[0]   = pixel;
         upleft_hist[0] = psu_pkg::ByteW'(b);
         if (x < psu_pkg::MaxLineBytes) begin
            prior_line[x] = pixel;
            if (x + 1 > prior_extent) prior_extent = x + 1;
         end
         want.pixel_byte     = pixel;
         want.end_of_line    = (col_pos + 1 >= eff_len);
         want.unknown_filter = (row_filter == psu_pkg::FILT_UNKNOWN);
         if (want.end_of_line) begin
            col_pos      = 0;
            in_first_row = 1'b0;
         end else begin
            col_pos++;
         end
         expected_pixels.push_back(want);
      end
   endtask

   // drop valid, wait for every pixel word, then let a trailing filter byte clear
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input psu_pkg::csr_index_type idx,
                            input logic [psu_pkg::CsrDataW-1:0] value);
      settle_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      reg_writes++;
      if (idx == psu_pkg::REG_LINE_LENGTH) begin
         line_len_reg = value;
         // a longer line would read prior entries never written; restart the image
         if (!in_first_row && clamp_len(value) - 1 > prior_extent) force_start = 1'b1;
      end else begin
         pix_bytes_reg = value[psu_pkg::PixSizeW-1:0];
      end
   endtask

   task automatic send_byte(input logic [psu_pkg::ByteW-1:0] value, input logic sof);
      int                    gap;
      psu_pkg::req_word_type w;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      w.data_byte      = value;
      w.start_of_image = sof | force_start;
      force_start      = 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      rebuild_byte(w);
   endtask

   task automatic send_row(input logic [psu_pkg::ByteW-1:0] filt, input logic sof,
                           input int unsigned pixels);
      send_byte(filt, sof);
      for (int unsigned i = 0; i < pixels; i++)
         send_byte(psu_pkg::ByteW'($urandom), 1'b0);
   endtask

   task automatic test_reset_values();
      // line_length 2 and pixel_bytes 1 out of reset: one pixel per line
      send_row(psu_pkg::FILT_SUB, 1'b0, 1);
      send_row(psu_pkg::FILT_UP, 1'b0, 1);
      send_row(psu_pkg::FILT_PAETH, 1'b0, 1);
   endtask

   task automatic test_filter_types();
      logic [psu_pkg::ByteW-1:0] patterns [4] = '{8'hFF, 8'h00, 8'h80, 8'h7F};
      logic [psu_pkg::ByteW-1:0] filters  [7] = '{psu_pkg::FILT_NONE, psu_pkg::FILT_SUB,
                                                  psu_pkg::FILT_UP, psu_pkg::FILT_AVG,
                                                  psu_pkg::FILT_PAETH,
                                                  psu_pkg::FILT_UNKNOWN, 8'hFF};
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(4));
      write_reg(psu_pkg::REG_PIXEL_BYTES, pix_word(2));
      for (int r = 0; r < 7; r++) begin
         send_byte(filters[r], r == 0);
         for (int i = 0; i < 3; i++) send_byte(patterns[(r + i) % 4], 1'b0);
      end
   endtask

   task automatic test_short_lines();
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(0));
      send_row(psu_pkg::FILT_SUB, 1'b1, 1);
      send_row(psu_pkg::FILT_UP, 1'b0, 1);
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(1));
      send_row(psu_pkg::FILT_AVG, 1'b0, 1);
      send_row(psu_pkg::FILT_PAETH, 1'b0, 1);
   endtask

   task automatic test_pixel_size_clamp();
      int unsigned sizes [4] = '{0, 9, 15, 8};
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(12));
      for (int k = 0; k < 4; k++) begin
         write_reg(psu_pkg::REG_PIXEL_BYTES, pix_word(sizes[k]));
         send_row(psu_pkg::FILT_SUB, 1'b1, 11);
         send_row(psu_pkg::FILT_PAETH, 1'b0, 11);
      end
   endtask

   task automatic test_length_change_mid_line();
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(10));
      write_reg(psu_pkg::REG_PIXEL_BYTES, pix_word(1));
      send_row(psu_pkg::FILT_SUB, 1'b1, 6);
      // shrink below the current column: the next byte closes the line
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(5));
      send_byte(8'h3C, 1'b0);
      send_row(psu_pkg::FILT_UP, 1'b0, 4);
      send_row(psu_pkg::FILT_AVG, 1'b0, 4);
   endtask

   task automatic test_start_mid_line();
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(8));
      send_row(psu_pkg::FILT_UP, 1'b1, 3);
      send_row(psu_pkg::FILT_AVG, 1'b1, 7);
      send_row(psu_pkg::FILT_PAETH, 1'b0, 7);
   endtask

   task automatic test_backpressure();
      write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(30));
      write_reg(psu_pkg::REG_PIXEL_BYTES, pix_word(3));
      holds_requested++;
      send_row(psu_pkg::FILT_PAETH, 1'b1, 29);
      send_row(psu_pkg::FILT_AVG, 1'b0, 29);
   endtask

   task automatic test_random_images(input int budget, input int send_pct, input int recv_pct);
      int                        sent, rows, pick;
      int unsigned               len, px, eff_len;
      logic [psu_pkg::ByteW-1:0] filt;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 5) len = $urandom_range(0, 1);
         else if (pick < 90) len = $urandom_range(2, 24);
         else len = $urandom_range(25, 200);
         pick = $urandom_range(99);
         if (pick < 85) px = $urandom_range(1, 8);
         else if (pick < 92) px = 0;
         else px = $urandom_range(9, 15);
         write_reg(psu_pkg::REG_LINE_LENGTH, psu_pkg::CsrDataW'(len));
         write_reg(psu_pkg::REG_PIXEL_BYTES, pix_word(px));
         eff_len = clamp_len(psu_pkg::ColW'(len));
         rows = $urandom_range(1, 5);
         for (int r = 0; r < rows; r++) begin
            filt = ($urandom_range(99) < 85) ? psu_pkg::ByteW'($urandom_range(0, 4))
                                             : psu_pkg::ByteW'($urandom_range(5, 255));
            send_byte(filt, r == 0);
            // a stray start flag now and then breaks the line structure
            for (int unsigned i = 1; i < eff_len; i++)
               send_byte(psu_pkg::ByteW'($urandom), $urandom_range(99) < 2);
            sent += eff_len;
         end
      end
   endtask

   // result side: random ready, plus a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel word %02h arrived with nothing expected", rsp_word.pixel_byte);
            error_count++;
         end else begin
            want_pixel = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_word.pixel_byte !== want_pixel.pixel_byte) begin
               $error("pixel_byte: expected %02h, got %02h",
                      want_pixel.pixel_byte, rsp_word.pixel_byte);
               error_count++;
            end
            if (rsp_word.end_of_line !== want_pixel.end_of_line) begin
               $error("end_of_line: expected %0b, got %0b",
                      want_pixel.end_of_line, rsp_word.end_of_line);
               error_count++;
            end
            if (rsp_word.unknown_filter !== want_pixel.unknown_filter) begin
               $error("unknown_filter: expected %0b, got %0b",
                      want_pixel.unknown_filter, rsp_word.unknown_filter);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      for (int i = 0; i < psu_pkg::MaxLineBytes; i++) prior_line[i] = '0;
      for (int i = 0; i < psu_pkg::MaxPixelBytes; i++) begin
         left_hist[i]   = '0;
         upleft_hist[i] = '0;
      end
      col_pos       = 0;
      in_first_row  = 1'b1;
      row_filter    = psu_pkg::FILT_NONE;
      line_len_reg  = psu_pkg::ColW'(2);
      pix_bytes_reg = psu_pkg::PixSizeW'(1);
      prior_extent  = 0;
      force_start   = 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 63;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_filter_types();
      test_short_lines();
      test_pixel_size_clamp();
      test_length_change_mid_line();
      test_start_mid_line();
      test_random_images(60, 9, 63);
      test_backpressure();
      test_random_images(60, 63, 9);
      test_random_images(60, 0, 0);
      settle_idle();

      $display("tb_top: %0d bytes sent, %0d pixel words checked, %0d register writes",
               bytes_sent, pixels_checked, reg_writes);
      $display("tb_top: covered every filter, unknown types, size clamps, mid-line changes and a long output stall");
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
